[rtl/uart_frx_pkg.sv]
// ----------------------------------------------------------------------------
// uart_frx_pkg
// shared types, constants and byte codes of the uart frame receiver
// ----------------------------------------------------------------------------
package uart_frx_pkg;

    // frame limits
    localparam int MAX_PAYLOAD = 64;
    localparam int POS_DEPTH   = 13;
    localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int          CFG_IDX_W    = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CTRL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BATT = CFG_IDX_W'(1);
    localparam logic [7:0]  CTRL_ADDR_RST = 8'h01;
    localparam logic [7:0]  BATT_ADDR_RST = 8'h02;

    // line codes
    localparam logic [7:0] BYTE_START = 8'h3A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;

    // command codes in byte 1
    localparam logic [7:0] CMD_RESPONSE = 8'h01;
    localparam logic [7:0] CMD_UPLOAD   = 8'h02;

    // result kinds
    localparam logic [2:0] KIND_CSUM_FAIL = 3'd0;
    localparam logic [2:0] KIND_RESPONSE  = 3'd1;
    localparam logic [2:0] KIND_UPLOAD    = 3'd2;
    localparam logic [2:0] KIND_BATTERY   = 3'd3;
    localparam logic [2:0] KIND_IGNORED   = 3'd4;
    localparam logic [2:0] KIND_LEN_ERR   = 3'd5;

    typedef enum logic [1:0] {
        OP_START,
        OP_APPEND1,
        OP_APPEND2,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       gate;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  item_code;
        logic        success;
        logic [7:0]  fault_code;
        logic [31:0] hall_count;
        logic [7:0]  speed_mode;
        logic [7:0]  undervolt_mode;
        logic [7:0]  assist_mode;
        logic [7:0]  supply_mode;
        logic [7:0]  repair_state;
        logic [15:0] battery_value;
    } t_result;

endpackage

[rtl/uart_frx_front.sv]
// ----------------------------------------------------------------------------
// uart_frx_front
// accepts received bytes, tracks frame and cr state, emits frame commands
// ----------------------------------------------------------------------------
module uart_frx_front import uart_frx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_gate_on,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic r_in_frame;
    logic r_cr_pending;
    logic n_in_frame;
    logic n_cr_pending;
    logic w_accept;

    assign w_accept = i_in_valid && !i_q_status.full;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_cr_pending = r_cr_pending;
        o_push       = 1'b0;
        o_cmd.op     = OP_APPEND1;
        o_cmd.data   = i_rx_byte;
        o_cmd.gate   = i_gate_on;
        if (w_accept) begin
            if (i_rx_byte == BYTE_START) begin
                o_push       = 1'b1;
                o_cmd.op     = OP_START;
                n_in_frame   = 1'b1;
                n_cr_pending = 1'b0;
            end else if (r_in_frame) begin
                if (r_cr_pending) begin
                    o_push = 1'b1;
                    if (i_rx_byte == BYTE_LF) begin
                        o_cmd.op     = OP_FINISH;
                        n_in_frame   = 1'b0;
                        n_cr_pending = 1'b0;
                    end else if (i_rx_byte == BYTE_CR) begin
                        // held cr becomes payload, new cr stays pending
                        o_cmd.op   = OP_APPEND1;
                        o_cmd.data = BYTE_CR;
                    end else begin
                        o_cmd.op     = OP_APPEND2;
                        n_cr_pending = 1'b0;
                    end
                end else if (i_rx_byte == BYTE_CR) begin
                    n_cr_pending = 1'b1;
                end else begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_APPEND1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_cr_pending <= 1'b0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_cr_pending <= n_cr_pending;
        end
    end

endmodule

[rtl/uart_frx_queue.sv]
// ----------------------------------------------------------------------------
// uart_frx_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
module uart_frx_queue import uart_frx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    assign o_cmd           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/uart_frx_back.sv]
// ----------------------------------------------------------------------------
// uart_frx_back
// frame gathering, checksum, decode and result register
// ----------------------------------------------------------------------------
module uart_frx_back import uart_frx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_q_status  i_q_status,
    input  logic [7:0] i_ctrl_addr,
    input  logic [7:0] i_batt_addr,
    input  logic       i_out_stall,
    output logic       o_pop,
    output logic       o_valid,
    output t_result    o_result
);

    typedef struct packed {
        logic [POS_DEPTH-1:0][7:0] pos;
        logic [COUNT_W-1:0]        count;
        logic [15:0]               sum;
        logic [7:0]                last0;
        logic [7:0]                last1;
        logic                      ovf;
    } t_frame;

    function automatic t_frame f_append(t_frame s, logic [7:0] b);
        t_frame r;
        r = s;
        if (!s.ovf) begin
            if (s.count >= COUNT_W'(MAX_PAYLOAD)) begin
                r.ovf = 1'b1;
            end else begin
                for (int i = 0; i < POS_DEPTH; i++) begin
                    if (s.count == COUNT_W'(i)) begin
                        r.pos[i] = b;
                    end
                end
                if (s.count >= COUNT_W'(2)) begin
                    r.sum = s.sum + {8'h00, s.last0};
                end
                r.last0 = s.last1;
                r.last1 = b;
                r.count = s.count + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_result f_decode(t_frame s, logic gate, logic [7:0] ctrl,
                                         logic [7:0] batt);
        t_result r;
        r = '0;
        if (s.ovf || s.count < COUNT_W'(2)) begin
            r.kind = KIND_LEN_ERR;
        end else if (s.sum[7:0] != s.last0 || s.sum[15:8] != s.last1) begin
            r.kind = KIND_CSUM_FAIL;
        end else if (s.pos[0] == ctrl && gate) begin
            if (s.pos[1] == CMD_RESPONSE) begin
                r.kind      = KIND_RESPONSE;
                r.item_code = s.pos[3];
                r.success   = (s.pos[4] != 8'h00);
            end else if (s.pos[1] == CMD_UPLOAD) begin
                r.kind           = KIND_UPLOAD;
                r.fault_code     = s.pos[3];
                r.hall_count     = {s.pos[7], s.pos[6], s.pos[5], s.pos[4]};
                r.speed_mode     = s.pos[8];
                r.undervolt_mode = s.pos[9];
                r.assist_mode    = s.pos[10];
                r.supply_mode    = s.pos[11];
                r.repair_state   = s.pos[12];
            end else begin
                r.kind = KIND_IGNORED;
            end
        end else if (s.pos[0] == batt) begin
            r.kind          = KIND_BATTERY;
            r.item_code     = s.pos[1];
            r.battery_value = {s.pos[4], s.pos[3]};
        end else begin
            r.kind = KIND_IGNORED;
        end
        return r;
    endfunction

    t_frame  r_frame;
    t_frame  n_frame;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_result n_result;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = !i_q_status.empty && (i_cmd.op != OP_FINISH || w_out_free);
    assign o_valid    = r_out_valid;
    assign o_result   = r_result;

    always_comb begin
        n_frame     = r_frame;
        n_result    = r_result;
        n_out_valid = r_out_valid && i_out_stall;
        if (o_pop) begin
            case (i_cmd.op)
                OP_START: begin
                    n_frame = '0;
                end
                OP_APPEND1: begin
                    n_frame = f_append(r_frame, i_cmd.data);
                end
                OP_APPEND2: begin
                    n_frame = f_append(f_append(r_frame, BYTE_CR), i_cmd.data);
                end
                OP_FINISH: begin
                    n_result    = f_decode(r_frame, i_cmd.gate, i_ctrl_addr, i_batt_addr);
                    n_out_valid = 1'b1;
                    n_frame     = '0;
                end
                default: begin
                    n_frame = r_frame;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

[rtl/uart_frame_receiver_checksum_top.sv]
// ----------------------------------------------------------------------------
// uart_frame_receiver_checksum_top
// uart frame receiver with 16-bit additive checksum and command decode
// ----------------------------------------------------------------------------
// Takes one received byte per transaction, at up to one transaction per
// cycle. A 0x3A byte opens (or restarts) a frame, CR LF closes it, and the
// closing LF produces exactly one result transaction; no other byte produces
// one. The input is stalled only when the four-entry command queue between the
// byte classifier and the frame engine is full. That happens only while a
// frame-end command waits at the head of the queue because the previous result
// still sits unread in the output register under stall, and the commands of
// the bytes behind it fill the remaining entries. The front classifies a byte
// in the cycle it is accepted and writes its command into the queue at that
// same edge (a CR that only becomes pending writes nothing). The frame engine
// takes a command at the next edge at the earliest, and a closing LF puts its
// result into the output register at that edge, so a result is offered once
// its LF command has passed through the queue and the output register. The
// address registers (index 0 controller, index 1 battery) are always ready and
// are meant to be written while the block is idle; other indices are ignored.
// ----------------------------------------------------------------------------
module uart_frame_receiver_checksum_top import uart_frx_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input transaction
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_gate_on,
    // result output transaction
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_frame_kind,
    output logic [7:0]           o_item_code,
    output logic                 o_success,
    output logic [7:0]           o_fault_code,
    output logic [31:0]          o_hall_count,
    output logic [7:0]           o_speed_mode,
    output logic [7:0]           o_undervolt_mode,
    output logic [7:0]           o_assist_mode,
    output logic [7:0]           o_supply_mode,
    output logic [7:0]           o_repair_state,
    output logic [15:0]          o_battery_value,
    // configuration write transaction
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // address registers
    logic [7:0] r_ctrl_addr;
    logic [7:0] r_batt_addr;

    // front to queue
    logic      w_push;
    t_cmd      w_push_cmd;
    // queue to back
    t_cmd      w_q_cmd;
    t_q_status w_q_status;
    logic      w_pop;
    t_result   w_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_addr <= CTRL_ADDR_RST;
            r_batt_addr <= BATT_ADDR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_CTRL: r_ctrl_addr <= i_cfg_data;
                CFG_IDX_BATT: r_batt_addr <= i_cfg_data;
                default: begin
                    // unknown register, write dropped
                end
            endcase
        end
    end

    // byte classifier: frame and cr tracking
    uart_frx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_gate_on  (i_gate_on),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // decoupling queue, lets the front run while a result waits
    uart_frx_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_q_cmd),
        .o_status (w_q_status)
    );

    // frame engine: positional capture, running sum, decode
    uart_frx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_q_cmd),
        .i_q_status  (w_q_status),
        .i_ctrl_addr (r_ctrl_addr),
        .i_batt_addr (r_batt_addr),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .o_result    (w_result)
    );

    assign o_frame_kind     = w_result.kind;
    assign o_item_code      = w_result.item_code;
    assign o_success        = w_result.success;
    assign o_fault_code     = w_result.fault_code;
    assign o_hall_count     = w_result.hall_count;
    assign o_speed_mode     = w_result.speed_mode;
    assign o_undervolt_mode = w_result.undervolt_mode;
    assign o_assist_mode    = w_result.assist_mode;
    assign o_supply_mode    = w_result.supply_mode;
    assign o_repair_state   = w_result.repair_state;
    assign o_battery_value  = w_result.battery_value;

    // queue never reads as both full and empty
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue reports full and empty together");

    // back only pops a command that is there
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    // a pushed command never lands in a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("push into full queue");

    // hall count stays zero for every kind other than upload
    a_hall_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_kind != KIND_UPLOAD) |-> (o_hall_count == 32'h0))
        else $error("hall count set outside upload");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the uart frame receiver with checksum and decode
// ----------------------------------------------------------------------------
// Drives received bytes one transaction at a time, with random gaps on the
// byte side and random stall on the result side. A scoreboard class keeps
// its own copy of the frame state and both address registers. It works out
// the expected report on every closing LF and compares each result
// transaction, field by field, with the oldest report still due. A directed
// set of frames comes first. Random frames follow under several address
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top import uart_frx_pkg::*;;

    // spare register index, all upper bits set, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(8'hFE);
    // cycles allowed for the front, the queue, the engine and the output register
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;

    // ------------------------------------------------------------------------
    // scoreboard: frame state copy, address registers and the reports due
    // ------------------------------------------------------------------------
    class frame_report_predictor;
        logic [7:0]  ctrl_addr;
        logic [7:0]  batt_addr;
        bit          in_frame;
        bit          cr_pending;
        bit          overflowed;
        int unsigned kept;
        logic [15:0] sum;
        logic [7:0]  pos [POS_DEPTH];
        logic [7:0]  tail [2];
        t_result     due_reports [$];
        int unsigned mismatches;
        int unsigned reports_checked;
        int unsigned kind_tally [8];

        function new();
            ctrl_addr       = CTRL_ADDR_RST;
            batt_addr       = BATT_ADDR_RST;
            mismatches      = 0;
            reports_checked = 0;
            foreach (kind_tally[k]) kind_tally[k] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            in_frame   = 1'b0;
            cr_pending = 1'b0;
            overflowed = 1'b0;
            kept       = 0;
            sum        = '0;
            foreach (pos[k]) pos[k] = '0;
            tail[0]    = '0;
            tail[1]    = '0;
        endfunction

        function void set_address(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_IDX_CTRL)
                ctrl_addr = val;
            else if (idx == CFG_IDX_BATT)
                batt_addr = val;
        endfunction

        // one payload byte into the frame; the sum always trails by two bytes
        function void keep_byte(logic [7:0] b);
            if (overflowed)
                return;
            if (kept >= MAX_PAYLOAD) begin
                overflowed = 1'b1;
                return;
            end
            if (kept < POS_DEPTH)
                pos[kept] = b;
            if (kept >= 2)
                sum = sum + 16'(tail[0]);
            tail[0] = tail[1];
            tail[1] = b;
            kept++;
        endfunction

        function void note_byte(logic [7:0] b, logic gate);
            t_result r;
            if (b == BYTE_START) begin
                clear_frame();
                in_frame = 1'b1;
                return;
            end
            if (!in_frame)
                return;
            if (cr_pending) begin
                if (b == BYTE_LF) begin
                    r = '0;
                    if (overflowed || kept < 2) begin
                        r.kind = KIND_LEN_ERR;
                    end else if (sum[7:0] != tail[0] || sum[15:8] != tail[1]) begin
                        r.kind = KIND_CSUM_FAIL;
                    end else if (pos[0] == ctrl_addr && gate) begin
                        if (pos[1] == CMD_RESPONSE) begin
                            r.kind      = KIND_RESPONSE;
                            r.item_code = pos[3];
                            r.success   = (pos[4] != 8'h00);
                        end else if (pos[1] == CMD_UPLOAD) begin
                            r.kind           = KIND_UPLOAD;
                            r.fault_code     = pos[3];
                            r.hall_count     = {pos[7], pos[6], pos[5], pos[4]};
                            r.speed_mode     = pos[8];
                            r.undervolt_mode = pos[9];
                            r.assist_mode    = pos[10];
                            r.supply_mode    = pos[11];
                            r.repair_state   = pos[12];
                        end else begin
                            r.kind = KIND_IGNORED;
                        end
                    end else if (pos[0] == batt_addr) begin
                        r.kind          = KIND_BATTERY;
                        r.item_code     = pos[1];
                        r.battery_value = {pos[4], pos[3]};
                    end else begin
                        r.kind = KIND_IGNORED;
                    end
                    due_reports.push_back(r);
                    kind_tally[r.kind]++;
                    clear_frame();
                    return;
                end
                // the held CR was payload after all
                keep_byte(BYTE_CR);
                if (b == BYTE_CR)
                    return;
                cr_pending = 1'b0;
                keep_byte(b);
                return;
            end
            if (b == BYTE_CR)
                cr_pending = 1'b1;
            else
                keep_byte(b);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch: %s", msg);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want)
                flag($sformatf("report %0d %s expected %0h got %0h",
                               reports_checked, name, want, seen));
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (due_reports.size() == 0) begin
                flag($sformatf("result with no frame end pending, kind %0d", got.kind));
                return;
            end
            want = due_reports.pop_front();
            compare_field("frame_kind",     32'(want.kind),           32'(got.kind));
            compare_field("item_code",      32'(want.item_code),      32'(got.item_code));
            compare_field("success",        32'(want.success),        32'(got.success));
            compare_field("fault_code",     32'(want.fault_code),     32'(got.fault_code));
            compare_field("hall_count",     want.hall_count,          got.hall_count);
            compare_field("speed_mode",     32'(want.speed_mode),     32'(got.speed_mode));
            compare_field("undervolt_mode", 32'(want.undervolt_mode), 32'(got.undervolt_mode));
            compare_field("assist_mode",    32'(want.assist_mode),    32'(got.assist_mode));
            compare_field("supply_mode",    32'(want.supply_mode),    32'(got.supply_mode));
            compare_field("repair_state",   32'(want.repair_state),   32'(got.repair_state));
            compare_field("battery_value",  32'(want.battery_value),  32'(got.battery_value));
            reports_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, block ports and the instance
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_rx_byte;
    logic                 i_gate_on;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_frame_kind;
    logic [7:0]           o_item_code;
    logic                 o_success;
    logic [7:0]           o_fault_code;
    logic [31:0]          o_hall_count;
    logic [7:0]           o_speed_mode;
    logic [7:0]           o_undervolt_mode;
    logic [7:0]           o_assist_mode;
    logic [7:0]           o_supply_mode;
    logic [7:0]           o_repair_state;
    logic [15:0]          o_battery_value;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    uart_frame_receiver_checksum_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_gate_on        (i_gate_on),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_kind     (o_frame_kind),
        .o_item_code      (o_item_code),
        .o_success        (o_success),
        .o_fault_code     (o_fault_code),
        .o_hall_count     (o_hall_count),
        .o_speed_mode     (o_speed_mode),
        .o_undervolt_mode (o_undervolt_mode),
        .o_assist_mode    (o_assist_mode),
        .o_supply_mode    (o_supply_mode),
        .o_repair_state   (o_repair_state),
        .o_battery_value  (o_battery_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    frame_report_predictor frame_reports = new();

    // payload of the frame under construction, checksum included once sealed
    logic [7:0]  frame_body [$];
    int unsigned bytes_sent = 0;
    // while set, neither side idles
    bit          calm = 1'b0;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    // random byte that never opens a frame
    function automatic logic [7:0] fresh_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == BYTE_START)
            b = b ^ 8'h01;
        return b;
    endfunction

    function automatic logic [7:0] pick_addr();
        logic [7:0] a;
        do
            a = 8'($urandom_range(0, 255));
        while (a == BYTE_START || a == BYTE_CR || a == BYTE_LF);
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // drivers: inputs change on the falling edge, handshakes seen on the rising
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic g);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        i_gate_on  <= g;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        frame_reports.note_byte(b, g);
        bytes_sent++;
    endtask

    task automatic write_address_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        frame_reports.set_address(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending until every due report is back; settle adds the pipeline tail
    task automatic hold_until_drained(input bit settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (frame_reports.due_reports.size() != 0)
            @(posedge i_clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // frame building
    // ------------------------------------------------------------------------
    task automatic fill_body(input int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(fresh_byte());
    endtask

    task automatic set_header(input logic [7:0] h0, input logic [7:0] h1);
        if (frame_body.size() > 0) frame_body[0] = h0;
        if (frame_body.size() > 1) frame_body[1] = h1;
    endtask

    // appends the sum low byte first; turns any CR LF pair in the body into CR 0x0B
    // and, where it can, reworks the last content byte so that the sum adds no CR LF or start byte
    task automatic seal_body(input bit corrupt);
        logic [15:0] s;
        int          n;
        int          tries;
        bit          bad;
        int          k;
        tries = 0;
        forever begin
            n = frame_body.size();
            for (int i = 1; i < n; i++)
                if (frame_body[i-1] == BYTE_CR && frame_body[i] == BYTE_LF)
                    frame_body[i] = 8'h0B;
            s = '0;
            foreach (frame_body[i]) s = s + 16'(frame_body[i]);
            bad = (s[7:0] == BYTE_START) || (s[15:8] == BYTE_START) ||
                  (s[7:0] == BYTE_CR && s[15:8] == BYTE_LF) ||
                  (n > 0 && frame_body[n-1] == BYTE_CR && s[7:0] == BYTE_LF);
            if (!bad || n < 3 || tries >= 32)
                break;
            frame_body[n-1] = fresh_byte();
            tries++;
        end
        frame_body.push_back(s[7:0]);
        frame_body.push_back(s[15:8]);
        if (corrupt) begin
            k = frame_body.size() - 1 - $urandom_range(0, 1);
            frame_body[k] = frame_body[k] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    task automatic send_frame(input logic end_gate);
        send_byte(BYTE_START, 1'($urandom_range(0, 1)));
        foreach (frame_body[i]) send_byte(frame_body[i], 1'($urandom_range(0, 1)));
        send_byte(BYTE_CR, 1'($urandom_range(0, 1)));
        // gate is taken from the closing LF
        send_byte(BYTE_LF, end_gate);
    endtask

    task automatic sealed_frame(input bit corrupt, input logic end_gate);
        seal_body(corrupt);
        send_frame(end_gate);
    endtask

    // one random case: mostly good frames of each kind, the rest broken or noise
    task automatic random_frame();
        int         sel;
        int         n;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] b;
        logic       g;
        bit         corrupt;
        sel     = $urandom_range(0, 99);
        h0      = frame_reports.ctrl_addr;
        h1      = CMD_RESPONSE;
        g       = 1'b1;
        corrupt = 1'b0;
        n       = $urandom_range(2, 8);
        if (sel < 18) begin
            // command response, defaults above
        end else if (sel < 34) begin
            h1 = CMD_UPLOAD;
            n  = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 12) : $urandom_range(13, 20);
        end else if (sel < 50) begin
            h0 = frame_reports.batt_addr;
            h1 = fresh_byte();
            g  = 1'($urandom_range(0, 1));
        end else if (sel < 56) begin
            // controller frame with the gate off
            h1 = $urandom_range(0, 1) ? CMD_RESPONSE : CMD_UPLOAD;
            g  = 1'b0;
        end else if (sel < 62) begin
            // unknown command byte
            h1 = fresh_byte() | 8'h04;
        end else if (sel < 68) begin
            h0 = fresh_byte();
            g  = 1'($urandom_range(0, 1));
        end else if (sel < 76) begin
            corrupt = 1'b1;
            g       = 1'($urandom_range(0, 1));
        end else if (sel < 80) begin
            // too short to hold a checksum
            frame_body.delete();
            if ($urandom_range(0, 1))
                frame_body.push_back(fresh_byte());
            send_frame(1'($urandom_range(0, 1)));
            return;
        end else if (sel < 83) begin
            // around the payload limit, often past it
            h1 = CMD_UPLOAD;
            n  = $urandom_range(61, 68);
        end else if (sel < 88) begin
            // aborted frame, restarted by the next start byte
            send_byte(BYTE_START, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 5)) send_byte(fresh_byte(), 1'($urandom_range(0, 1)));
        end else if (sel < 94) begin
            // line noise between frames
            repeat ($urandom_range(1, 6)) begin
                b = fresh_byte();
                if ($urandom_range(0, 3) == 0)
                    b = $urandom_range(0, 1) ? BYTE_CR : BYTE_LF;
                send_byte(b, 1'($urandom_range(0, 1)));
            end
            return;
        end else begin
            // unshaped bytes, start, CR and LF included
            send_byte(BYTE_START, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 15))
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_byte(BYTE_CR, 1'($urandom_range(0, 1)));
            send_byte(BYTE_LF, 1'($urandom_range(0, 1)));
            return;
        end
        fill_body(n);
        set_header(h0, h1);
        if (sel < 18 && n > 4 && $urandom_range(0, 3) == 0)
            frame_body[4] = 8'h00;
        sealed_frame(corrupt, g);
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned first;
        first = bytes_sent;
        while (bytes_sent - first < count)
            random_frame();
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall, every accepted transaction checked
    // ------------------------------------------------------------------------
    initial begin
        int run;
        int hold;
        @(negedge i_clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            repeat (run) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            hold = calm ? 0 : pick_gap();
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : take_report
        t_result got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.kind           = o_frame_kind;
            got.item_code      = o_item_code;
            got.success        = o_success;
            got.fault_code     = o_fault_code;
            got.hall_count     = o_hall_count;
            got.speed_mode     = o_speed_mode;
            got.undervolt_mode = o_undervolt_mode;
            got.assist_mode    = o_assist_mode;
            got.supply_mode    = o_supply_mode;
            got.repair_state   = o_repair_state;
            got.battery_value  = o_battery_value;
            frame_reports.check_report(got);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog, far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] a;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = '0;
        i_gate_on   = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, addresses at their reset values (controller 1, battery 2)
        // response with success set, item code at its top value
        frame_body = '{8'h01, 8'h01, 8'h55, 8'hFF, 8'h04};
        sealed_frame(1'b0, 1'b1);
        // response with success clear
        frame_body = '{8'h01, 8'h01, 8'hAA, 8'h00, 8'h00};
        sealed_frame(1'b0, 1'b1);
        // upload, every field at its top value
        frame_body = '{8'h01, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        sealed_frame(1'b0, 1'b1);
        // upload, walking bits through the hall count
        frame_body = '{8'h01, 8'h02, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08,
                       8'h10, 8'h20, 8'h40, 8'h7F, 8'hFE, 8'hFD};
        sealed_frame(1'b0, 1'b1);
        // upload too short for its fields, the checksum lands in the hall count and the rest must read as zero
        frame_body = '{8'h01, 8'h02, 8'h33, 8'h44, 8'h55};
        sealed_frame(1'b0, 1'b1);
        // battery with top code and value, gate off
        frame_body = '{8'h02, 8'hFF, 8'h11, 8'hFF, 8'hFF};
        sealed_frame(1'b0, 1'b0);
        frame_body = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00};
        sealed_frame(1'b0, 1'b1);
        // battery address alone, the checksum low byte lands in the item code
        frame_body = '{8'h02};
        sealed_frame(1'b0, 1'b1);
        // controller with the gate off
        frame_body = '{8'h01, 8'h01, 8'h12, 8'h34, 8'h56};
        sealed_frame(1'b0, 1'b0);
        // controller with an unknown command
        frame_body = '{8'h01, 8'h03, 8'h12, 8'h34};
        sealed_frame(1'b0, 1'b1);
        // unknown address
        frame_body = '{8'h7F, 8'h01, 8'h12, 8'h34};
        sealed_frame(1'b0, 1'b1);
        // damaged checksum
        frame_body = '{8'h01, 8'h01, 8'h21, 8'h43, 8'h65};
        sealed_frame(1'b1, 1'b1);
        // empty and one-byte frames
        frame_body.delete();
        send_frame(1'b1);
        frame_body = '{8'h00};
        send_frame(1'b1);
        // checksum only, a zero sum
        frame_body.delete();
        sealed_frame(1'b0, 1'b1);
        // exactly at the payload limit, then one byte past it
        fill_body(MAX_PAYLOAD - 2);
        set_header(8'h02, 8'h07);
        sealed_frame(1'b0, 1'b1);
        fill_body(MAX_PAYLOAD - 1);
        set_header(8'h01, CMD_UPLOAD);
        sealed_frame(1'b0, 1'b1);
        // CR without LF, a lone LF, and CR CR, all kept as payload
        frame_body = '{8'h02, 8'h0D, 8'h05, 8'h0A, 8'h0D, 8'h0D, 8'h07};
        sealed_frame(1'b0, 1'b1);
        // content ending in CR, just ahead of the checksum bytes and the closing CR LF
        frame_body = '{8'h02, 8'h03, 8'h04, 8'h05, 8'h0D};
        sealed_frame(1'b0, 1'b1);
        // frame restarted part way through
        send_byte(BYTE_START, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h01, 1'b0);
        frame_body = '{8'h01, 8'h01, 8'h09, 8'h08, 8'h07};
        sealed_frame(1'b0, 1'b1);
        // bytes outside any frame, CR LF among them, give nothing
        send_byte(BYTE_LF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(BYTE_CR, 1'b1);
        send_byte(BYTE_LF, 1'b1);
        send_byte(8'h00, 1'b1);

        // addresses at the bottom and top of their range
        hold_until_drained(1'b1);
        write_address_reg(CFG_IDX_CTRL, 8'h00);
        write_address_reg(CFG_IDX_BATT, 8'hFF);
        random_phase(250);

        // swapped extremes, a write to an index that does not exist, and a
        // stretch with no idling on either side
        hold_until_drained(1'b1);
        write_address_reg(CFG_IDX_CTRL, 8'hFF);
        write_address_reg(CFG_IDX_BATT, 8'h00);
        write_address_reg(CFG_IDX_SPARE, 8'h5A);
        calm = 1'b1;
        random_phase(110);
        calm = 1'b0;
        random_phase(150);

        // both addresses equal: the gate decides between controller and battery
        hold_until_drained(1'b1);
        a = pick_addr();
        write_address_reg(CFG_IDX_CTRL, a);
        write_address_reg(CFG_IDX_BATT, a);
        random_phase(250);

        // random distinct addresses, with a full drain in the middle
        hold_until_drained(1'b1);
        a = pick_addr();
        write_address_reg(CFG_IDX_CTRL, a);
        do
            a = pick_addr();
        while (a == frame_reports.ctrl_addr);
        write_address_reg(CFG_IDX_BATT, a);
        random_phase(130);
        hold_until_drained(1'b0);
        random_phase(130);

        // wind down: everything due must arrive, then nothing more may appear
        hold_until_drained(1'b1);
        $display("summary: %0d bytes driven, %0d frame reports compared, %0d mismatches",
                 bytes_sent, frame_reports.reports_checked, frame_reports.mismatches);
        $display("summary: response %0d, upload %0d, battery %0d, ignored %0d, bad sum %0d, bad length %0d",
                 frame_reports.kind_tally[KIND_RESPONSE], frame_reports.kind_tally[KIND_UPLOAD],
                 frame_reports.kind_tally[KIND_BATTERY], frame_reports.kind_tally[KIND_IGNORED],
                 frame_reports.kind_tally[KIND_CSUM_FAIL], frame_reports.kind_tally[KIND_LEN_ERR]);
        if (frame_reports.mismatches == 0 && frame_reports.due_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
